// File: hw/rtl/swl_pkg.sv
// swl_pkg: sizes, register indexes, result codes and cell types of the
// sliding window write limiter; depends on nothing
package swl_pkg;

   // sizes of the grant log, the deferral queue and the time stamps
   localparam int LOG_DEPTH   = 32;
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 32;

   localparam int LOG_CNT_W   = $clog2(LOG_DEPTH + 1);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int OPS_W         = 4;
   localparam int OPS_LIMIT_W   = 8;
   localparam int SUM_OPS_W     = 9;
   localparam int OPS_SUM_W     = SUM_OPS_W + 1;
   localparam int HEADER_W      = 8;
   localparam int SLOT_W        = 8;
   localparam int PAYLOAD_W     = 20;
   localparam int BYTES_W       = 21;
   localparam int BYTES_LIMIT_W = 27;
   localparam int BYTES_SUM_W   = BYTES_LIMIT_W + 1;
   localparam int WINDOW_W      = 32;
   localparam int STATUS_W      = 2;
   localparam int CMP_W         = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_OPS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_BYTES   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OPS_PER_REQ = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER      = 3'd4;

   // register values after reset
   localparam logic [OPS_LIMIT_W-1:0]   RESET_MAX_OPS     = 8'd128;
   localparam logic [BYTES_LIMIT_W-1:0] RESET_MAX_BYTES   = 27'd67108864;
   localparam logic [WINDOW_W-1:0]      RESET_WINDOW      = 32'd60000;
   localparam logic [OPS_W-1:0]         RESET_OPS_PER_REQ = 4'd4;
   localparam logic [HEADER_W-1:0]      RESET_HEADER      = 8'd4;

   // result codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED       = 2'd0,
      STATUS_QUEUE_GRANTED = 2'd1,
      STATUS_DEFERRED      = 2'd2,
      STATUS_DROPPED       = 2'd3
   } status_type;

   // one grant held in a log cell
   typedef struct packed {
      logic [TIME_BITS-1:0] stamp;
      logic [OPS_W-1:0]     ops;
      logic [BYTES_W-1:0]   bytes;
   } log_entry_type;

   // one deferred request held in a queue cell
   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic [PAYLOAD_W-1:0] payload;
   } queue_entry_type;

   // per-cell control: shift takes the neighbour's entry, load takes new data
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/swl_channels_if.sv
// swl_channels_if: valid/ready channel interfaces for requests, results
// and configuration writes; depends on swl_pkg

interface swl_req_if import swl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [TIME_BITS-1:0] now_time;
   logic [SLOT_W-1:0]    slot_index;
   logic [PAYLOAD_W-1:0] payload_size;

   modport source (output valid, kind, now_time, slot_index, payload_size, input ready);
   modport sink   (input valid, kind, now_time, slot_index, payload_size, output ready);
endinterface

interface swl_rsp_if import swl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SLOT_W-1:0]      granted_slot;
   logic [PAYLOAD_W-1:0]   granted_payload;
   logic [QUEUE_CNT_W-1:0] queued_count;
   logic                   last;

   modport source (output valid, status, granted_slot, granted_payload, queued_count, last,
                   input ready);
   modport sink   (input valid, status, granted_slot, granted_payload, queued_count, last,
                   output ready);
endinterface

interface swl_csr_if import swl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: hw/rtl/swl_log_cell.sv
// swl_log_cell: one cell of the grant log chain, holding a grant's time,
// operations and bytes; depends on swl_pkg
module swl_log_cell import swl_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  log_entry_type load_data,
   input  log_entry_type next_data,
   output log_entry_type entry
);

   log_entry_type entry_ff;
   log_entry_type entry_in;

   // shift towards the head, or take a new grant at the tail
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.shift) begin
         entry_in = next_data;
      end else if (ctrl.load) begin
         entry_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hw/rtl/swl_queue_cell.sv
// swl_queue_cell: one cell of the deferral queue chain, holding a request's
// slot and payload size; depends on swl_pkg
module swl_queue_cell import swl_pkg::*; (
   input  logic            clock,
   input  cell_ctrl_type   ctrl,
   input  queue_entry_type load_data,
   input  queue_entry_type next_data,
   output queue_entry_type entry
);

   queue_entry_type entry_ff;
   queue_entry_type entry_in;

   // shift towards the head, or take a deferred request at the tail
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.shift) begin
         entry_in = next_data;
      end else if (ctrl.load) begin
         entry_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hw/rtl/sliding_window_write_limiter_unit.sv
// sliding_window_write_limiter_unit: top level, control sequencer, window sums
// and the two cell chains; depends on swl_pkg, swl_channels_if and the cells
//
//   channel    dir   transfer carries
//   req_chan   in    kind, now_time, slot_index, payload_size
//   rsp_chan   out   status, granted_slot, granted_payload, queued_count, last
//   csr_chan   in    reg_index, wdata (always ready)
//
// a save passes through prune and save, a tick through prune and drain; prune
// retires the expired log entries one per cycle from the head cell, and drain
// grants queued requests one per cycle from the queue head cell while the
// result register is free. reset is synchronous and returns to idle; no clearing pass.
// a stalled result register holds the sequencer in its save or drain step;
// a new request is taken while the last result still waits.
module sliding_window_write_limiter_unit import swl_pkg::*; (
   input logic clock,
   input logic reset,
   swl_req_if.sink   req_chan,
   swl_rsp_if.source rsp_chan,
   swl_csr_if.sink   csr_chan
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_PRUNE = 4'b0010,
      S_SAVE  = 4'b0100,
      S_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [OPS_LIMIT_W-1:0]   cfg_max_ops_ff;
   logic [BYTES_LIMIT_W-1:0] cfg_max_bytes_ff;
   logic [WINDOW_W-1:0]      cfg_window_ff;
   logic [OPS_W-1:0]         cfg_ops_req_ff;
   logic [HEADER_W-1:0]      cfg_header_ff;

   // current item
   logic                 kind_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   // window and queue bookkeeping
   logic [LOG_CNT_W-1:0]     log_count_ff, log_count_in;
   logic [SUM_OPS_W-1:0]     sum_ops_ff, sum_ops_in;
   logic [BYTES_LIMIT_W-1:0] sum_bytes_ff, sum_bytes_in;
   logic [QUEUE_CNT_W-1:0]   queue_count_ff, queue_count_in;

   // queue grant held back until it is known whether it is the last one
   logic                   pend_valid_ff, pend_valid_in;
   queue_entry_type        pend_entry_ff;
   logic [QUEUE_CNT_W-1:0] pend_qcount_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [PAYLOAD_W-1:0]   rsp_payload_ff;
   logic [QUEUE_CNT_W-1:0] rsp_qcount_ff;
   logic                   rsp_last_ff;

   // result to load into the result register
   logic                   emit;
   status_type             emit_status;
   logic [SLOT_W-1:0]      emit_slot;
   logic [PAYLOAD_W-1:0]   emit_payload;
   logic [QUEUE_CNT_W-1:0] emit_qcount;
   logic                   emit_last;

   // chain controls and data
   logic            log_shift, log_load;
   logic            queue_shift, queue_load;
   logic            pend_load;
   cell_ctrl_type   log_ctrl   [LOG_DEPTH];
   cell_ctrl_type   queue_ctrl [QUEUE_DEPTH];
   log_entry_type   log_entries   [LOG_DEPTH+1];
   queue_entry_type queue_entries [QUEUE_DEPTH+1];
   log_entry_type   log_new;
   queue_entry_type queue_new;

   logic                 req_fire;
   logic [TIME_BITS-1:0] head_age;
   logic                 head_expired;
   logic [PAYLOAD_W-1:0] cand_payload;
   logic [BYTES_W-1:0]   charge_bytes;
   logic [OPS_SUM_W-1:0]   ops_total;
   logic [BYTES_SUM_W-1:0] bytes_total;
   logic                 log_full;
   logic                 fits;
   logic                 out_free;
   logic                 queue_full;
   logic                 queue_empty;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // age of the oldest grant against the window
   assign head_age     = now_ff - log_entries[0].stamp;
   assign head_expired = (log_count_ff != '0) && (CMP_W'(head_age) > CMP_W'(cfg_window_ff));

   // budget check for the candidate: the new save or the queue head
   assign cand_payload = kind_ff ? payload_ff : queue_entries[0].payload;
   assign charge_bytes = BYTES_W'(cand_payload) + BYTES_W'(cfg_header_ff);
   assign ops_total    = OPS_SUM_W'(sum_ops_ff) + OPS_SUM_W'(cfg_ops_req_ff);
   assign bytes_total  = BYTES_SUM_W'(sum_bytes_ff) + BYTES_SUM_W'(charge_bytes);
   assign log_full     = (log_count_ff == LOG_CNT_W'(LOG_DEPTH));
   assign fits         = !log_full
                         && (ops_total <= OPS_SUM_W'(cfg_max_ops_ff))
                         && (bytes_total <= BYTES_SUM_W'(cfg_max_bytes_ff));

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign queue_full  = (queue_count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (queue_count_ff == '0);

   assign log_new.stamp     = now_ff;
   assign log_new.ops       = cfg_ops_req_ff;
   assign log_new.bytes     = charge_bytes;
   assign queue_new.slot    = slot_ff;
   assign queue_new.payload = payload_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      log_count_in   = log_count_ff;
      sum_ops_in     = sum_ops_ff;
      sum_bytes_in   = sum_bytes_ff;
      queue_count_in = queue_count_ff;
      pend_valid_in  = pend_valid_ff;
      pend_load      = 1'b0;
      log_shift      = 1'b0;
      log_load       = 1'b0;
      queue_shift    = 1'b0;
      queue_load     = 1'b0;
      emit           = 1'b0;
      emit_status    = STATUS_GRANTED;
      emit_slot      = slot_ff;
      emit_payload   = payload_ff;
      emit_qcount    = queue_count_ff;
      emit_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_PRUNE;
            end
         end
         S_PRUNE: begin
            if (head_expired) begin
               log_shift    = 1'b1;
               log_count_in = log_count_ff - LOG_CNT_W'(1);
               sum_ops_in   = sum_ops_ff - SUM_OPS_W'(log_entries[0].ops);
               sum_bytes_in = sum_bytes_ff - BYTES_LIMIT_W'(log_entries[0].bytes);
            end else begin
               state_in = kind_ff ? S_SAVE : S_DRAIN;
            end
         end
         S_SAVE: begin
            if (out_free) begin
               emit = 1'b1;
               priority if (fits) begin
                  log_load     = 1'b1;
                  log_count_in = log_count_ff + LOG_CNT_W'(1);
                  sum_ops_in   = sum_ops_ff + SUM_OPS_W'(cfg_ops_req_ff);
                  sum_bytes_in = sum_bytes_ff + BYTES_LIMIT_W'(charge_bytes);
                  emit_status  = STATUS_GRANTED;
               end else if (queue_full) begin
                  emit_status = STATUS_DROPPED;
               end else begin
                  queue_load     = 1'b1;
                  queue_count_in = queue_count_ff + QUEUE_CNT_W'(1);
                  emit_status    = STATUS_DEFERRED;
               end
               emit_qcount = queue_count_in;
               state_in    = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               emit_status  = STATUS_QUEUE_GRANTED;
               emit_slot    = pend_entry_ff.slot;
               emit_payload = pend_entry_ff.payload;
               emit_qcount  = pend_qcount_ff;
               emit         = pend_valid_ff;
               if (!queue_empty && fits) begin
                  log_load       = 1'b1;
                  queue_shift    = 1'b1;
                  log_count_in   = log_count_ff + LOG_CNT_W'(1);
                  sum_ops_in     = sum_ops_ff + SUM_OPS_W'(cfg_ops_req_ff);
                  sum_bytes_in   = sum_bytes_ff + BYTES_LIMIT_W'(charge_bytes);
                  queue_count_in = queue_count_ff - QUEUE_CNT_W'(1);
                  pend_load      = 1'b1;
                  pend_valid_in  = 1'b1;
                  emit_last      = 1'b0;
               end else begin
                  pend_valid_in = 1'b0;
                  emit_last     = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         log_count_ff     <= '0;
         sum_ops_ff       <= '0;
         sum_bytes_ff     <= '0;
         queue_count_ff   <= '0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         cfg_max_ops_ff   <= RESET_MAX_OPS;
         cfg_max_bytes_ff <= RESET_MAX_BYTES;
         cfg_window_ff    <= RESET_WINDOW;
         cfg_ops_req_ff   <= RESET_OPS_PER_REQ;
         cfg_header_ff    <= RESET_HEADER;
      end else begin
         state_ff       <= state_in;
         log_count_ff   <= log_count_in;
         sum_ops_ff     <= sum_ops_in;
         sum_bytes_ff   <= sum_bytes_in;
         queue_count_ff <= queue_count_in;
         pend_valid_ff  <= pend_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_chan.valid) begin
            unique case (csr_chan.reg_index)
               REG_MAX_OPS:     cfg_max_ops_ff   <= csr_chan.wdata[OPS_LIMIT_W-1:0];
               REG_MAX_BYTES:   cfg_max_bytes_ff <= csr_chan.wdata[BYTES_LIMIT_W-1:0];
               REG_WINDOW:      cfg_window_ff    <= csr_chan.wdata[WINDOW_W-1:0];
               REG_OPS_PER_REQ: cfg_ops_req_ff   <= csr_chan.wdata[OPS_W-1:0];
               REG_HEADER:      cfg_header_ff    <= csr_chan.wdata[HEADER_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff    <= req_chan.kind;
         now_ff     <= req_chan.now_time;
         slot_ff    <= req_chan.slot_index;
         payload_ff <= req_chan.payload_size;
      end
      if (pend_load) begin
         pend_entry_ff  <= queue_entries[0];
         pend_qcount_ff <= queue_count_in;
      end
      if (emit) begin
         rsp_status_ff  <= emit_status;
         rsp_slot_ff    <= emit_slot;
         rsp_payload_ff <= emit_payload;
         rsp_qcount_ff  <= emit_qcount;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.granted_slot    = rsp_slot_ff;
   assign rsp_chan.granted_payload = rsp_payload_ff;
   assign rsp_chan.queued_count    = rsp_qcount_ff;
   assign rsp_chan.last            = rsp_last_ff;

   // grant log chain, oldest grant in cell 0
   assign log_entries[LOG_DEPTH] = '0;
   for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_log
      assign log_ctrl[i].shift = log_shift;
      assign log_ctrl[i].load  = log_load && (log_count_ff == LOG_CNT_W'(i));
      swl_log_cell u_cell (
         .clock     (clock),
         .ctrl      (log_ctrl[i]),
         .load_data (log_new),
         .next_data (log_entries[i+1]),
         .entry     (log_entries[i])
      );
   end

   // deferral queue chain, oldest request in cell 0
   assign queue_entries[QUEUE_DEPTH] = '0;
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
      assign queue_ctrl[i].shift = queue_shift;
      assign queue_ctrl[i].load  = queue_load && (queue_count_ff == QUEUE_CNT_W'(i));
      swl_queue_cell u_cell (
         .clock     (clock),
         .ctrl      (queue_ctrl[i]),
         .load_data (queue_new),
         .next_data (queue_entries[i+1]),
         .entry     (queue_entries[i])
      );
   end

   // checks
   a_log_bound: assert property (@(posedge clock) disable iff (reset)
      log_count_ff <= LOG_CNT_W'(LOG_DEPTH))
      else $error("log count beyond log depth");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond queue depth");

   a_empty_sums: assert property (@(posedge clock) disable iff (reset)
      (log_count_ff == '0) |-> (sum_ops_ff == '0) && (sum_bytes_ff == '0))
      else $error("window sums not zero with an empty log");

   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held queue grant left behind at idle");

endmodule
